// ===== rtl/core/bounded_product_subset_enumerator_top_assert.svh =====
// Assertion macros for the enumerator top level.
`ifndef BOUNDED_PRODUCT_SUBSET_ENUMERATOR_TOP_ASSERT_SVH
`define BOUNDED_PRODUCT_SUBSET_ENUMERATOR_TOP_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define BPSE_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define BPSE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== rtl/core/bpse_pkg.sv =====
// Types and constants of the bounded-product subset enumerator.
package bpse_pkg;

  localparam int SCAN_W = 9;
  localparam int ID_W   = 8;

  localparam logic [1:0] ACT_LOAD    = 2'd0;
  localparam logic [1:0] ACT_RESTART = 2'd1;
  localparam logic [1:0] ACT_NEXT    = 2'd2;

  localparam logic [2:0] REG_MODULUS  = 3'd0;
  localparam logic [2:0] REG_BASE     = 3'd1;
  localparam logic [2:0] REG_CAP_LOW  = 3'd2;
  localparam logic [2:0] REG_CAP_HIGH = 3'd3;
  localparam logic [2:0] REG_SUBSET   = 3'd4;
  localparam logic [2:0] REG_POOL_CNT = 3'd5;

  // shared unit operations
  localparam logic [1:0] OP_MULX = 2'd0;  // exact 128 x 64 product
  localparam logic [1:0] OP_MULM = 2'd1;  // modular product
  localparam logic [1:0] OP_RED  = 2'd2;  // reduce b modulo M

  typedef struct packed {
    logic       start;
    logic [1:0] op;
  } alu_req_t;

endpackage

// ===== rtl/core/bounded_product_subset_enumerator_top.sv =====
// Top level of the bounded-product subset enumerator: sequencer, stacks, pool.
// Each input transfer is one action: load a pool entry, restart, or request the
// next record. Load and restart are taken without stalling the input. A next
// request walks the backtracking search over a shared bit-serial unit: every
// candidate is read from the pool and given an exact product check, an accepted
// one has its residue computed (with the multiplicand reduced first when it
// needs it), and a record has its key computed and is then loaded into the
// output register, so the time to a record grows with the candidates rejected
// or backed out of; a done answer goes from the check to the output register.
// The input is stalled while a request is in progress; a finished record sits
// in the output register while the next action is taken.
`include "bounded_product_subset_enumerator_top_assert.svh"
module bounded_product_subset_enumerator_top #(
  parameter int POOL_DEPTH = 256,
  parameter int MAX_SUBSET = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  action,
  input  logic [7:0]  entry_index,
  input  logic [63:0] entry_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] record_key,
  output logic [63:0] record_id,
  output logic        done_res
);
  import bpse_pkg::*;

  localparam int AW    = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
  localparam int LVL_W = (MAX_SUBSET > 1) ? $clog2(MAX_SUBSET) : 1;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_RD    = 3'd2;
  localparam logic [2:0] S_PX    = 3'd3;
  localparam logic [2:0] S_RS    = 3'd4;
  localparam logic [2:0] S_KEY   = 3'd5;
  localparam logic [2:0] S_EMIT  = 3'd6;

  logic [63:0] modulus, base_residue, cap_low, cap_high;
  logic [3:0]  subset_size;
  logic [8:0]  pool_count;

  logic [2:0]        state;
  logic [LVL_W-1:0]  level;
  logic [LVL_W-1:0]  lvl_m1;
  logic [SCAN_W-1:0] scan;
  logic [SCAN_W-1:0] n_eff;
  logic              exhausted;

  logic [ID_W-1:0] index_stack   [MAX_SUBSET];
  logic [63:0]     prod_lo_stack [MAX_SUBSET];
  logic [63:0]     prod_hi_stack [MAX_SUBSET];
  logic [63:0]     residue_stack [MAX_SUBSET];

  logic [63:0] vreg;
  logic [63:0] pend_key;
  logic [63:0] pend_id;
  logic        pend_done;
  logic [63:0] id_word;

  logic        in_acc;
  logic        pool_we;
  logic [63:0] pool_rdata;

  alu_req_t     req;
  logic [127:0] alu_a;
  logic [63:0]  alu_b;
  logic         alu_done;
  logic [191:0] alu_res;

  logic        ok;
  logic        size_bad;
  logic        full_path;
  logic [4:0]  lvl_p1;

  assign in_stall  = (state != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign pool_we   = in_acc && (action == ACT_LOAD) && ({1'b0, entry_index} < 9'(POOL_DEPTH));
  assign lvl_m1    = level - LVL_W'(1);
  assign n_eff     = (pool_count > 9'(POOL_DEPTH)) ? 9'(POOL_DEPTH) : pool_count;
  assign size_bad  = (subset_size == 4'd0) || (subset_size > 4'(MAX_SUBSET));
  assign lvl_p1    = 5'(level) + 5'd1;
  assign full_path = (lvl_p1 >= {1'b0, subset_size});
  assign ok        = (alu_res[191:128] == 64'd0) &&
                     (alu_res[127:0] < {cap_high, cap_low});

  bpse_ram #(.WIDTH(64), .DEPTH(POOL_DEPTH)) u_pool (
    .clk   (clk),
    .we    (pool_we),
    .waddr (entry_index[AW-1:0]),
    .wdata (entry_value),
    .raddr (scan[AW-1:0]),
    .rdata (pool_rdata)
  );

  bpse_alu u_alu (
    .clk     (clk),
    .rst     (rst),
    .req     (req),
    .a       (alu_a),
    .b       (alu_b),
    .modulus (modulus),
    .done    (alu_done),
    .result  (alu_res)
  );

  // drive the shared unit from the sequencer state
  always_comb begin
    req   = '0;
    alu_a = 128'd0;
    alu_b = 64'd0;
    case (state)
      S_RD: begin
        req.start = 1'b1;
        req.op    = OP_MULX;
        alu_a     = (level == '0) ? 128'd1 : {prod_hi_stack[lvl_m1], prod_lo_stack[lvl_m1]};
        alu_b     = pool_rdata;
      end
      S_PX: begin
        req.start = alu_done && ok;
        req.op    = (level == '0) ? OP_RED : OP_MULM;
        alu_a     = {64'd0, residue_stack[lvl_m1]};
        alu_b     = vreg;
      end
      S_RS: begin
        req.start = alu_done && full_path;
        req.op    = OP_MULM;
        alu_a     = {64'd0, alu_res[63:0]};
        alu_b     = base_residue;
      end
      default: begin
        req = '0;
      end
    endcase
  end

  always_comb begin
    id_word = 64'd0;
    for (int k = 0; k < MAX_SUBSET; k++) begin
      if (LVL_W'(k) <= level) begin
        id_word[ID_W*k +: ID_W] = index_stack[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      modulus      <= 64'd1;
      base_residue <= 64'd0;
      cap_low      <= 64'd0;
      cap_high     <= 64'd0;
      subset_size  <= 4'd1;
      pool_count   <= 9'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MODULUS:  modulus      <= cfg_data;
        REG_BASE:     base_residue <= cfg_data;
        REG_CAP_LOW:  cap_low      <= cfg_data;
        REG_CAP_HIGH: cap_high     <= cfg_data;
        REG_SUBSET:   subset_size  <= cfg_data[3:0];
        REG_POOL_CNT: pool_count   <= cfg_data[8:0];
        default:      ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      level     <= '0;
      scan      <= '0;
      exhausted <= 1'b1;
      out_valid <= 1'b0;
    end else begin
      if (state == S_EMIT && (!out_valid || !out_stall)) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_acc) begin
            case (action)
              ACT_RESTART: begin
                level     <= '0;
                scan      <= '0;
                exhausted <= 1'b0;
              end
              ACT_NEXT: state <= S_CHECK;
              default:  ;
            endcase
          end
        end
        S_CHECK: begin
          if (exhausted || size_bad) begin
            exhausted <= 1'b1;
            pend_key  <= 64'd0;
            pend_id   <= 64'd0;
            pend_done <= 1'b1;
            state     <= S_EMIT;
          end else if (scan < n_eff) begin
            state <= S_RD;
          end else if (level == '0) begin
            exhausted <= 1'b1;
          end else begin
            level <= lvl_m1;
            scan  <= {1'b0, index_stack[lvl_m1]} + 9'd1;
          end
        end
        S_RD: begin
          vreg  <= pool_rdata;
          state <= S_PX;
        end
        S_PX: begin
          if (alu_done) begin
            if (ok) begin
              index_stack[level]   <= scan[ID_W-1:0];
              prod_hi_stack[level] <= alu_res[127:64];
              prod_lo_stack[level] <= alu_res[63:0];
              state                <= S_RS;
            end else if (level == '0) begin
              exhausted <= 1'b1;
              state     <= S_CHECK;
            end else begin
              level <= lvl_m1;
              scan  <= {1'b0, index_stack[lvl_m1]} + 9'd1;
              state <= S_CHECK;
            end
          end
        end
        S_RS: begin
          if (alu_done) begin
            residue_stack[level] <= alu_res[63:0];
            if (full_path) begin
              state <= S_KEY;
            end else begin
              level <= level + LVL_W'(1);
              scan  <= scan + 9'd1;
              state <= S_CHECK;
            end
          end
        end
        S_KEY: begin
          if (alu_done) begin
            pend_key  <= alu_res[63:0];
            pend_id   <= id_word;
            pend_done <= 1'b0;
            scan      <= scan + 9'd1;
            state     <= S_EMIT;
          end
        end
        S_EMIT: begin
          // hold until the output register is free
          if (!out_valid || !out_stall) begin
            record_key <= pend_key;
            record_id  <= pend_id;
            done_res   <= pend_done;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `BPSE_ASSERT_NOW(done_zero, out_valid && done_res, record_key == 64'd0 && record_id == 64'd0)
  `BPSE_ASSERT_NOW(level_range, 1'b1, 5'(level) < 5'(MAX_SUBSET))
  `BPSE_ASSERT_NOW(unit_idle, alu_done, state == S_PX || state == S_RS || state == S_KEY)
  `BPSE_ASSERT_NEXT(emit_shows, state == S_EMIT && (!out_valid || !out_stall), out_valid)

endmodule

// ===== rtl/core/bpse_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module bpse_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/bpse_alu.sv =====
// Bit-serial shared multiply / modular multiply / reduce unit.
module bpse_alu (
  input  logic               clk,
  input  logic               rst,
  input  bpse_pkg::alu_req_t req,
  input  logic [127:0]       a,
  input  logic [63:0]        b,
  input  logic [63:0]        modulus,
  output logic               done,
  output logic [191:0]       result
);
  import bpse_pkg::*;

  logic         run;
  logic         pre;
  logic [5:0]   cnt;
  logic [1:0]   opr;
  logic [127:0] areg;
  logic [63:0]  breg;
  logic [63:0]  sh;
  logic [191:0] acc;
  logic [191:0] acc_next;
  logic [64:0]  dbl;
  logic [64:0]  sum;
  logic [64:0]  rem;
  logic [1:0]   eff_op;
  logic         mz;
  logic [64:0]  mext;
  logic         last;

  assign mz     = (modulus == 64'd0);
  assign mext   = {1'b0, modulus};
  assign eff_op = pre ? OP_RED : opr;
  assign last   = (cnt == 6'd63);
  assign result = acc;

  always_comb begin
    dbl = {acc[63:0], 1'b0};
    if (!mz && dbl >= mext) begin
      dbl = dbl - mext;
    end
    sum = {1'b0, dbl[63:0]} + (sh[63] ? {1'b0, areg[63:0]} : 65'd0);
    if (!mz && sum >= mext) begin
      sum = sum - mext;
    end
    rem = {acc[63:0], sh[63]};
    if (!mz && rem >= mext) begin
      rem = rem - mext;
    end
    case (eff_op)
      OP_MULX: acc_next = {acc[190:0], 1'b0} + (sh[63] ? {64'd0, areg} : 192'd0);
      OP_MULM: acc_next = {128'd0, sum[63:0]};
      OP_RED:  acc_next = {128'd0, rem[63:0]};
      default: acc_next = acc;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      pre  <= 1'b0;
      done <= 1'b0;
      cnt  <= 6'd0;
    end else begin
      done <= run && last && !pre && !req.start;
      if (req.start) begin
        run  <= 1'b1;
        cnt  <= 6'd0;
        acc  <= 192'd0;
        opr  <= req.op;
        areg <= a;
        breg <= b;
        // reduce an unreduced multiplicand first
        if (req.op == OP_MULM && !mz && a[63:0] >= modulus) begin
          pre <= 1'b1;
          sh  <= a[63:0];
        end else begin
          pre <= 1'b0;
          sh  <= b;
        end
      end else if (run) begin
        cnt <= cnt + 6'd1;
        if (last && pre) begin
          pre  <= 1'b0;
          areg <= {64'd0, acc_next[63:0]};
          acc  <= 192'd0;
          sh   <= breg;
        end else begin
          sh  <= {sh[62:0], 1'b0};
          acc <= acc_next;
          if (last) begin
            run <= 1'b0;
          end
        end
      end
    end
  end

endmodule

// ===== verif/bpse_record_checker.sv =====
// Checker for the subset enumerator: predicts every record and compares transfers.
`timescale 1ns / 1ps
module bpse_record_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [1:0]  action,
  input  logic [7:0]  entry_index,
  input  logic [63:0] entry_value,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [63:0] record_key,
  input  logic [63:0] record_id,
  input  logic        done_res,
  output int          errors,
  output int          pending
);
  import bpse_pkg::*;

  typedef struct packed {
    logic [63:0] key;
    logic [63:0] id;
    logic        done;
  } record_t;

  record_t expected_records[$];

  logic [63:0] modulus, base_residue, cap_lo, cap_hi;
  logic [3:0]  subset_size;
  logic [8:0]  pool_count;

  logic [63:0] pool[256];
  logic [7:0]  idx_st[8];
  logic [63:0] prod_hi_st[8];
  logic [63:0] prod_lo_st[8];
  logic [63:0] res_st[8];
  int          lvl;
  int          scan;
  logic        exhausted;

  function automatic logic [63:0] mod_mul(logic [63:0] a, logic [63:0] b);
    logic [127:0] p;
    if (modulus == 64'd0) return a * b;
    p = {64'd0, a % modulus} * {64'd0, b % modulus};
    p = p % {64'd0, modulus};
    return p[63:0];
  endfunction

  // Backtracking search up to the next subset under the cap.
  task automatic predict_next_record(output record_t rec);
    int          n;
    int          j;
    logic [63:0] v, ph, pl, vr;
    logic [191:0] full;
    logic        ok;
    logic        found;
    rec = '{key: 64'd0, id: 64'd0, done: 1'b1};
    found = 1'b0;
    if (subset_size == 4'd0 || subset_size > 4'd8) exhausted = 1'b1;
    n = (pool_count > 9'd256) ? 256 : int'(pool_count);
    while (!exhausted && !found) begin
      ok = 1'b0;
      if (scan < n && lvl < 8) begin
        v = pool[scan[7:0]];
        ph = (lvl != 0) ? prod_hi_st[lvl-1] : 64'd0;
        pl = (lvl != 0) ? prod_lo_st[lvl-1] : 64'd1;
        full = {64'd0, ph, pl} * {128'd0, v};
        ok = (full[191:128] == 64'd0) && (full[127:0] < {cap_hi, cap_lo});
        if (ok) begin
          vr = (modulus == 64'd0) ? v : v % modulus;
          idx_st[lvl] = scan[7:0];
          prod_hi_st[lvl] = full[127:64];
          prod_lo_st[lvl] = full[63:0];
          res_st[lvl] = (lvl != 0) ? mod_mul(res_st[lvl-1], vr) : vr;
          if (lvl + 1 >= int'(subset_size)) begin
            for (j = 0; j <= lvl; j++) rec.id |= {56'd0, idx_st[j]} << (8 * j);
            rec.key = mod_mul(base_residue, res_st[lvl]);
            rec.done = 1'b0;
            scan++;
            found = 1'b1;
          end else begin
            lvl++;
            scan = int'(idx_st[lvl-1]) + 1;
          end
        end
      end
      if (!ok && !found) begin
        if (lvl == 0) begin
          exhausted = 1'b1;
        end else begin
          lvl--;
          scan = int'(idx_st[lvl]) + 1;
        end
      end
    end
  endtask

  always @(posedge clk) begin
    record_t rec;
    if (rst) begin
      modulus = 64'd1;
      base_residue = 64'd0;
      cap_lo = 64'd0;
      cap_hi = 64'd0;
      subset_size = 4'd1;
      pool_count = 9'd0;
      for (int i = 0; i < 8; i++) begin
        idx_st[i] = 8'd0;
        prod_hi_st[i] = 64'd0;
        prod_lo_st[i] = 64'd0;
        res_st[i] = 64'd0;
      end
      lvl = 0;
      scan = 0;
      exhausted = 1'b1;
      expected_records.delete();
      errors = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_records.size() == 0) begin
          $error("unexpected record transfer key %h id %h done %b",
                 record_key, record_id, done_res);
          errors++;
        end else begin
          rec = expected_records.pop_front();
          if (record_key !== rec.key) begin
            $error("record_key expected %h actual %h", rec.key, record_key);
            errors++;
          end
          if (record_id !== rec.id) begin
            $error("record_id expected %h actual %h", rec.id, record_id);
            errors++;
          end
          if (done_res !== rec.done) begin
            $error("done_res expected %b actual %b", rec.done, done_res);
            errors++;
          end
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_MODULUS:  modulus = cfg_data;
          REG_BASE:     base_residue = cfg_data;
          REG_CAP_LOW:  cap_lo = cfg_data;
          REG_CAP_HIGH: cap_hi = cfg_data;
          REG_SUBSET:   subset_size = cfg_data[3:0];
          REG_POOL_CNT: pool_count = cfg_data[8:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        case (action)
          ACT_LOAD: pool[entry_index] = entry_value;
          ACT_RESTART: begin
            lvl = 0;
            scan = 0;
            exhausted = 1'b0;
          end
          ACT_NEXT: begin
            predict_next_record(rec);
            expected_records = {expected_records, rec};
          end
          default: ;
        endcase
      end
    end
    pending = expected_records.size();
  end
endmodule

// ===== verif/tb_bounded_product_subset_enumerator_top.sv =====
// Testbench top: clock, reset, stimulus and verdict for the subset enumerator.
`timescale 1ns / 1ps
module tb_bounded_product_subset_enumerator_top;
  import bpse_pkg::*;

  localparam int QUIET_LIMIT = 2000000;
  localparam int RANDOM_ITEMS = 850;
  localparam logic [1:0] ACT_SPARE = 2'd3;
  localparam logic [2:0] REG_SPARE = 3'd6;

  logic        clk, rst;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [63:0] cfg_data;
  logic        in_valid, in_stall;
  logic [1:0]  action;
  logic [7:0]  entry_index;
  logic [63:0] entry_value;
  logic        out_valid, out_stall;
  logic [63:0] record_key, record_id;
  logic        done_res;
  int          errors, pending;

  int tx_idle_pct, rx_idle_pct;
  int items_sent;
  int quiet;

  bounded_product_subset_enumerator_top dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .action(action),
    .entry_index(entry_index), .entry_value(entry_value),
    .out_valid(out_valid), .out_stall(out_stall),
    .record_key(record_key), .record_id(record_id), .done_res(done_res)
  );

  bpse_record_checker checker_i (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .action(action),
    .entry_index(entry_index), .entry_value(entry_value),
    .out_valid(out_valid), .out_stall(out_stall),
    .record_key(record_key), .record_id(record_id), .done_res(done_res),
    .errors(errors), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(negedge clk) out_stall <= ($urandom_range(99) < rx_idle_pct);

  always @(posedge clk) begin
    if (rst) begin
      quiet <= 0;
    end else if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet >= QUIET_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Call at a falling edge; returns at the falling edge after the transfer.
  task automatic send_item(logic [1:0] act, logic [7:0] idx, logic [63:0] val);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    action <= act;
    entry_index <= idx;
    entry_value <= val;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    items_sent++;
  endtask

  // Leaves the write enable high; the caller drops it after the last write.
  task automatic write_reg(logic [2:0] idx, logic [63:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
  endtask

  // Hold until every record is back, then let the block settle.
  task automatic drain();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  task automatic setup(logic [63:0] m, logic [63:0] b, logic [63:0] cl, logic [63:0] ch,
                       logic [63:0] r, logic [63:0] pc);
    drain();
    write_reg(REG_MODULUS, m);
    write_reg(REG_BASE, b);
    write_reg(REG_CAP_LOW, cl);
    write_reg(REG_CAP_HIGH, ch);
    write_reg(REG_SUBSET, r);
    write_reg(REG_POOL_CNT, pc);
    if ($urandom_range(3) == 0) write_reg(REG_SPARE + 3'($urandom_range(1)), rand64());
    cfg_we <= 1'b0;
  endtask

  // Ascending pool: small steps keep products low, wide steps reach overflow.
  task automatic load_pool(int n, bit wide);
    logic [63:0] v;
    v = wide ? rand64() >> 5 : 64'($urandom_range(3));
    for (int i = 0; i < n; i++) begin
      send_item(ACT_LOAD, 8'(i), v);
      v = v + (wide ? (rand64() >> 5) : 64'($urandom_range(7)));
    end
  endtask

  task automatic random_phase(int n, bit noisy);
    logic [63:0] m, b, cl, ch, r;
    int reqs, pick;
    pick = $urandom_range(4);
    m = (pick == 0) ? 64'd0 : (pick == 1) ? 64'd1 : (pick == 2) ? '1 :
        (pick == 3) ? 64'($urandom_range(1000, 2)) : rand64();
    pick = $urandom_range(3);
    b = (pick == 0) ? 64'd0 : (pick == 1) ? '1 : (pick == 2) ? 64'd1 : rand64();
    pick = $urandom_range(5);
    case (pick)
      0: begin cl = 64'd0; ch = 64'd0; end
      1: begin cl = '1; ch = '1; end
      2: begin cl = 64'($urandom_range(5000)); ch = 64'd0; end
      3: begin cl = rand64(); ch = 64'd0; end
      default: begin cl = rand64(); ch = rand64() >> $urandom_range(63); end
    endcase
    pick = $urandom_range(19);
    r = (pick < 14) ? 64'($urandom_range(4, 1)) : (pick < 18) ? 64'($urandom_range(8, 5)) :
        (pick == 18) ? {rand64() & ~64'hf} : (rand64() & ~64'hf) | 64'($urandom_range(15, 9));
    setup(m, b, cl, ch, r, {rand64() & ~64'h1ff} | 64'(n));
    load_pool(n, $urandom_range(2) == 0);
    send_item(ACT_RESTART, 8'($urandom), rand64());
    reqs = $urandom_range(25, 3);
    for (int i = 0; i < reqs; i++) begin
      pick = $urandom_range(99);
      if (noisy && pick < 4) send_item(ACT_SPARE, 8'($urandom), rand64());
      else if (noisy && pick < 8 && n > 0)
        send_item(ACT_LOAD, 8'($urandom_range(n - 1)), rand64());
      else if (noisy && pick < 10) send_item(ACT_RESTART, 8'($urandom), rand64());
      else send_item(ACT_NEXT, 8'($urandom), rand64());
    end
  endtask

  initial begin
    int target;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    action = ACT_LOAD;
    entry_index = '0;
    entry_value = '0;
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    items_sent = 0;
    repeat (4) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: request while exhausted, empty pool, unused action.
    send_item(ACT_NEXT, 8'd0, 64'd0);
    send_item(ACT_SPARE, 8'hff, '1);
    send_item(ACT_RESTART, 8'd0, 64'd0);
    send_item(ACT_NEXT, 8'd0, 64'd0);
    send_item(ACT_NEXT, 8'd0, 64'd0);
    // Modulus zero, full cap, values that overflow 128 bits.
    setup(64'd0, '1, '1, '1, 64'd3, 64'd5);
    send_item(ACT_LOAD, 8'd0, 64'd0);
    send_item(ACT_LOAD, 8'd1, 64'd1);
    send_item(ACT_LOAD, 8'd2, 64'hffff_ffff_0000_0000);
    send_item(ACT_LOAD, 8'd3, '1);
    send_item(ACT_LOAD, 8'd4, '1);
    send_item(ACT_RESTART, 8'd0, 64'd0);
    repeat (8) send_item(ACT_NEXT, 8'd0, 64'd0);
    // Bad subset sizes answer done.
    setup('1, 64'd7, 64'd100, 64'd0, 64'd0, 64'd5);
    send_item(ACT_RESTART, 8'd0, 64'd0);
    send_item(ACT_NEXT, 8'd0, 64'd0);
    setup('1, 64'd7, 64'd100, 64'd0, 64'd15, 64'd5);
    send_item(ACT_RESTART, 8'd0, 64'd0);
    send_item(ACT_NEXT, 8'd0, 64'd0);
    // Unordered pool: a failed check at the top level ends the scan.
    setup(64'd97, 64'd3, 64'd50, 64'd0, 64'd1, 64'd3);
    send_item(ACT_LOAD, 8'd0, 64'd60);
    send_item(ACT_LOAD, 8'd1, 64'd2);
    send_item(ACT_LOAD, 8'd2, 64'd3);
    send_item(ACT_RESTART, 8'd0, 64'd0);
    send_item(ACT_NEXT, 8'd0, 64'd0);

    for (int mode = 0; mode < 3; mode++) begin
      drain();
      tx_idle_pct = (mode == 0) ? 24 : (mode == 1) ? 54 : 0;
      rx_idle_pct = (mode == 0) ? 54 : (mode == 1) ? 24 : 0;
      target = items_sent + RANDOM_ITEMS / 3;
      if (mode == 2) begin
        // Whole pool, count above the depth.
        setup(64'd1000003, 64'd5, '1, '1, 64'd1, 64'h1ff);
        for (int i = 0; i < 256; i++) send_item(ACT_LOAD, 8'(i), 64'(i) * 64'd3 + 64'd1);
        send_item(ACT_RESTART, 8'd0, 64'd0);
        repeat (12) send_item(ACT_NEXT, 8'd0, 64'd0);
        setup(64'd1000003, 64'd5, '1, '1, 64'd2, 64'd256);
        send_item(ACT_RESTART, 8'd0, 64'd0);
        repeat (6) send_item(ACT_NEXT, 8'd0, 64'd0);
      end
      while (items_sent < target) begin
        random_phase(($urandom_range(9) == 0) ? $urandom_range(1) : $urandom_range(10, 2),
                     $urandom_range(2) != 0);
      end
    end

    drain();
    if (errors == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
